// ===== design/prs_pkg.sv =====
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants and types for the probe RTT statistics block.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int RTT_BITS_DEF   = 20;

  // loss field: hundredths of a percent, full loss is 10000
  localparam int               LOSS_W     = 14;
  localparam logic [LOSS_W-1:0] LOSS_FULL  = 14'd10000;
  localparam logic [LOSS_W-1:0] LOSS_SCALE = 14'd10000;

  // summaries waiting between front and back
  localparam int QUEUE_DEPTH = 2;

  // back-end sequencer
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_MUL_A    = 8'b0000_0010,
    S_MUL_B    = 8'b0000_0100,
    S_DIFF     = 8'b0000_1000,
    S_SQRT     = 8'b0001_0000,
    S_DIV_LOSS = 8'b0010_0000,
    S_DIV_MEAN = 8'b0100_0000,
    S_DIV_JIT  = 8'b1000_0000
  } back_state_t;

endpackage

// ===== design/prs_front.sv =====
// ----------------------------------------------------------------------------
// prs_front
// Per-probe accumulation of counts, min, max, sum and sum of squares;
// pushes a snapshot on the last probe and clears.
// ----------------------------------------------------------------------------
module prs_front import prs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RTT_BITS   = RTT_BITS_DEF,
  parameter int SNAP_W     = 4*COUNT_BITS + 5*RTT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                answered,
  input  logic [RTT_BITS-1:0] rtt,
  input  logic                last,
  output logic                push,
  output logic [SNAP_W-1:0]   snap
);

  localparam int C  = COUNT_BITS;
  localparam int R  = RTT_BITS;
  localparam int SW = C + R;
  localparam int QW = C + 2*R;

  logic [C-1:0]  probe_r, probe_nxt;
  logic [C-1:0]  reply_r, reply_nxt;
  logic [R-1:0]  min_r, min_nxt;
  logic [R-1:0]  max_r, max_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0] sq_r, sq_nxt;
  logic [2*R-1:0] rtt_sq;

  assign rtt_sq = {{R{1'b0}}, rtt} * {{R{1'b0}}, rtt};

  always_comb begin
    probe_nxt = probe_r;
    reply_nxt = reply_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    if (accept) begin
      if (probe_r != {C{1'b1}}) probe_nxt = probe_r + 1'b1;
      if (answered) begin
        if (rtt < min_r) min_nxt = rtt;
        if (rtt > max_r) max_nxt = rtt;
        // saturated reply count: min/max still track, sums stop
        if (reply_r != {C{1'b1}}) begin
          reply_nxt = reply_r + 1'b1;
          sum_nxt   = sum_r + SW'(rtt);
          sq_nxt    = sq_r + QW'(rtt_sq);
        end
      end
    end
  end

  assign push = accept & last;
  assign snap = {probe_nxt, reply_nxt, min_nxt, max_nxt, sum_nxt, sq_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      probe_r <= '0;
      reply_r <= '0;
      min_r   <= '1;
      max_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
    end else begin
      probe_r <= probe_nxt;
      reply_r <= reply_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
    end
  end

endmodule

// ===== design/prs_queue.sv =====
// ----------------------------------------------------------------------------
// prs_queue
// Short FIFO of run snapshots between the front and the back.
// ----------------------------------------------------------------------------
module prs_queue import prs_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == NW'(DEPTH));
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(push && !pop) |-> count_r == $past(count_r) + 1'b1)
    else $error("queue fill count lost a push");

endmodule

// ===== design/prs_divider.sv =====
// ----------------------------------------------------------------------------
// prs_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prs_divider #(
  parameter int DW = 32,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r, dvs_r, rem_nxt;
  logic [VW:0]   rem_sh, rem_diff;
  logic          ge;

  assign rem_sh   = {rem_r, quo_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt  = ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/prs_back.sv =====
// ----------------------------------------------------------------------------
// prs_back
// Summary sequencer: shift-add products, digit-by-digit square root and
// three divisions on one shared divider, then one result strobe.
// ----------------------------------------------------------------------------
module prs_back import prs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RTT_BITS   = RTT_BITS_DEF,
  parameter int SNAP_W     = 4*COUNT_BITS + 5*RTT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [SNAP_W-1:0]     q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  output logic [COUNT_BITS-1:0] out_sent,
  output logic [COUNT_BITS-1:0] out_replies,
  output logic [LOSS_W-1:0]     out_loss,
  output logic [RTT_BITS-1:0]   out_min,
  output logic [RTT_BITS-1:0]   out_max,
  output logic [RTT_BITS-1:0]   out_mean,
  output logic [RTT_BITS-1:0]   out_jitter
);

  localparam int C    = COUNT_BITS;
  localparam int R    = RTT_BITS;
  localparam int SW   = C + R;
  localparam int QW   = C + 2*R;
  localparam int PW   = 2*SW;
  localparam int LW   = C + LOSS_W;
  localparam int DW   = C + ((R > LOSS_W) ? R : LOSS_W);
  localparam int CNTW = $clog2(SW + 1);

  // snapshot fields
  logic [C-1:0]  sn_sent, sn_n;
  logic [R-1:0]  sn_min, sn_max;
  logic [SW-1:0] sn_sum;
  logic [QW-1:0] sn_sq;

  assign {sn_sent, sn_n, sn_min, sn_max, sn_sum, sn_sq} = q_data;

  back_state_t   state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic          issued_r, issued_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [C-1:0]  sent_r, sent_nxt, n_r, n_nxt;
  logic [R-1:0]  min_r, min_nxt, max_r, max_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [QW-1:0] sq_r, sq_nxt;
  logic [PW-1:0] acc_r, acc_nxt, a_r, a_nxt;
  logic [SW-1:0] mq_r, mq_nxt;
  logic [SW+1:0] rem_r, rem_nxt;
  logic [SW-1:0] root_r, root_nxt;
  logic [LOSS_W-1:0] loss_r, loss_nxt;
  logic [R-1:0]  mean_r, mean_nxt;

  logic [C-1:0]      o_sent_r, o_sent_nxt, o_n_r, o_n_nxt;
  logic [LOSS_W-1:0] o_loss_r, o_loss_nxt;
  logic [R-1:0]      o_min_r, o_min_nxt, o_max_r, o_max_nxt;
  logic [R-1:0]      o_mean_r, o_mean_nxt, o_jit_r, o_jit_nxt;

  // shift-add step (multiplier MSB first)
  logic [PW-1:0] mcand, acc_step;
  assign mcand    = (state_r == S_MUL_A) ? PW'(sq_r) : PW'(sum_r);
  assign acc_step = {acc_r[PW-2:0], 1'b0} + (mq_r[SW-1] ? mcand : '0);

  // square root step, two radicand bits per cycle
  logic [SW+3:0] rem_sh, trial, sq_diff;
  logic          sq_ge;
  assign rem_sh  = {rem_r, a_r[PW-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign sq_diff = rem_sh - trial;
  assign sq_ge   = (rem_sh >= trial);

  // loss numerator
  logic [C-1:0]  lost;
  logic [LW-1:0] loss_num;
  assign lost     = sent_r - n_r;
  assign loss_num = {{LOSS_W{1'b0}}, lost} * {{C{1'b0}}, LOSS_SCALE};

  // shared divider: loss divides by probes sent, mean and jitter by replies
  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quo;
  logic [C-1:0]  div_divisor;

  assign div_divisor = (state_r == S_DIV_LOSS) ? sent_r : n_r;

  always_comb begin
    unique case (state_r)
      S_DIV_LOSS: div_dividend = DW'(loss_num);
      S_DIV_MEAN: div_dividend = DW'(sum_r);
      default:    div_dividend = DW'(root_r);
    endcase
  end

  prs_divider #(.DW(DW), .VW(C)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    issued_nxt    = issued_r;
    out_valid_nxt = 1'b0;
    sent_nxt = sent_r;  n_nxt   = n_r;
    min_nxt  = min_r;   max_nxt = max_r;
    sum_nxt  = sum_r;   sq_nxt  = sq_r;
    acc_nxt  = acc_r;   a_nxt   = a_r;   mq_nxt = mq_r;
    rem_nxt  = rem_r;   root_nxt = root_r;
    loss_nxt = loss_r;  mean_nxt = mean_r;
    o_sent_nxt = o_sent_r;  o_n_nxt   = o_n_r;   o_loss_nxt = o_loss_r;
    o_min_nxt  = o_min_r;   o_max_nxt = o_max_r;
    o_mean_nxt = o_mean_r;  o_jit_nxt = o_jit_r;
    q_pop     = 1'b0;
    div_start = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          sent_nxt = sn_sent;  n_nxt   = sn_n;
          min_nxt  = sn_min;   max_nxt = sn_max;
          sum_nxt  = sn_sum;   sq_nxt  = sn_sq;
          if (sn_n == '0) begin
            // no replies: fixed summary, no arithmetic
            out_valid_nxt = 1'b1;
            o_sent_nxt = sn_sent;
            o_n_nxt    = '0;
            o_loss_nxt = LOSS_FULL;
            o_min_nxt  = '0;
            o_max_nxt  = '0;
            o_mean_nxt = '0;
            o_jit_nxt  = '0;
          end else begin
            state_nxt = S_MUL_A;
            acc_nxt   = '0;
            mq_nxt    = {sn_n, {R{1'b0}}};
            cnt_nxt   = CNTW'(C);
          end
        end
      end
      S_MUL_A: begin
        // n * sum of squares
        acc_nxt = acc_step;
        mq_nxt  = {mq_r[SW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          a_nxt     = acc_step;
          acc_nxt   = '0;
          mq_nxt    = sum_r;
          cnt_nxt   = CNTW'(SW);
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_B: begin
        // sum squared
        acc_nxt = acc_step;
        mq_nxt  = {mq_r[SW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) state_nxt = S_DIFF;
      end
      S_DIFF: begin
        a_nxt     = (acc_r <= a_r) ? a_r - acc_r : '0;
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = CNTW'(SW);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        a_nxt    = {a_r[PW-3:0], 2'b00};
        rem_nxt  = sq_ge ? sq_diff[SW+1:0] : rem_sh[SW+1:0];
        root_nxt = {root_r[SW-2:0], sq_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          issued_nxt = 1'b0;
          state_nxt  = S_DIV_LOSS;
        end
      end
      S_DIV_LOSS: begin
        div_start  = !issued_r;
        issued_nxt = 1'b1;
        if (div_done) begin
          loss_nxt   = div_quo[LOSS_W-1:0];
          issued_nxt = 1'b0;
          state_nxt  = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        div_start  = !issued_r;
        issued_nxt = 1'b1;
        if (div_done) begin
          mean_nxt   = div_quo[R-1:0];
          issued_nxt = 1'b0;
          state_nxt  = S_DIV_JIT;
        end
      end
      S_DIV_JIT: begin
        div_start  = !issued_r;
        issued_nxt = 1'b1;
        if (div_done) begin
          issued_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          o_sent_nxt = sent_r;
          o_n_nxt    = n_r;
          o_loss_nxt = loss_r;
          o_min_nxt  = min_r;
          o_max_nxt  = max_r;
          o_mean_nxt = mean_r;
          o_jit_nxt  = div_quo[R-1:0];
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sent_r <= sent_nxt;  n_r    <= n_nxt;
    min_r  <= min_nxt;   max_r  <= max_nxt;
    sum_r  <= sum_nxt;   sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;   a_r    <= a_nxt;   mq_r <= mq_nxt;
    rem_r  <= rem_nxt;   root_r <= root_nxt;
    loss_r <= loss_nxt;  mean_r <= mean_nxt;
    o_sent_r <= o_sent_nxt;  o_n_r   <= o_n_nxt;   o_loss_r <= o_loss_nxt;
    o_min_r  <= o_min_nxt;   o_max_r <= o_max_nxt;
    o_mean_r <= o_mean_nxt;  o_jit_r <= o_jit_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_sent    = o_sent_r;
  assign out_replies = o_n_r;
  assign out_loss    = o_loss_r;
  assign out_min     = o_min_r;
  assign out_max     = o_max_r;
  assign out_mean    = o_mean_r;
  assign out_jitter  = o_jit_r;

  a_replies_le_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_n_r <= o_sent_r) else $error("more replies than probes");
  a_loss_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> o_loss_r <= LOSS_FULL) else $error("loss above full scale");
  a_no_reply_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (o_n_r == '0) |-> (o_loss_r == LOSS_FULL) && (o_max_r == '0))
    else $error("empty run summary wrong");
  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (o_n_r != '0) |-> (o_mean_r >= o_min_r) && (o_mean_r <= o_max_r))
    else $error("mean outside min/max");

endmodule

// ===== design/probe_rtt_statistics.sv =====
// ----------------------------------------------------------------------------
// probe_rtt_statistics
// Ping-style loss, RTT and jitter statistics over a run of echo probes.
// ----------------------------------------------------------------------------
// Flow: a last probe's summary strobes after bit-serial products, the root and
//   three divider passes; a run with no replies gets its fixed summary without
//   that arithmetic.
// Throughput: one probe word per cycle; busy rises only while two finished
//   runs wait for the back end. The receiver cannot stall the result strobe.
// Reset: synchronous, active low; clears statistics, queue and sequencer.
module probe_rtt_statistics import prs_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int RTT_BITS   = RTT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // probe word
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_probe_answered,
  input  logic [RTT_BITS-1:0]   in_rtt_us,
  input  logic                  in_last_probe,
  // summary word
  output logic                  out_valid,
  output logic [COUNT_BITS-1:0] out_probes_sent,
  output logic [COUNT_BITS-1:0] out_replies_received,
  output logic [LOSS_W-1:0]     out_loss_hundredths,
  output logic [RTT_BITS-1:0]   out_min_rtt_us,
  output logic [RTT_BITS-1:0]   out_max_rtt_us,
  output logic [RTT_BITS-1:0]   out_mean_rtt_us,
  output logic [RTT_BITS-1:0]   out_jitter_us
);

  // snapshot: sent, replies, min, max, sum, sum of squares
  localparam int SNAP_W = 4*COUNT_BITS + 5*RTT_BITS;

  logic              accept;
  logic              push, pop, q_empty, q_full;
  logic [SNAP_W-1:0] snap, q_data;

  // front keeps accepting probes while summaries are worked off behind it, until the queue fills
  assign busy   = q_full;
  assign accept = start & ~busy;

  // Front: min/max/counts plus a single RTT x RTT product feeding the
  // sum-of-squares add. On the last probe the updated totals are pushed as
  // one snapshot and the accumulators clear.
  prs_front #(
    .COUNT_BITS (COUNT_BITS),
    .RTT_BITS   (RTT_BITS),
    .SNAP_W     (SNAP_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .answered (in_probe_answered),
    .rtt      (in_rtt_us),
    .last     (in_last_probe),
    .push     (push),
    .snap     (snap)
  );

  // Decoupling queue: a new run can start while the previous summary
  // is still being computed.
  prs_queue #(
    .W     (SNAP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (snap),
    .pop   (pop),
    .rdata (q_data),
    .empty (q_empty),
    .full  (q_full)
  );

  // Back: n*sumsq and sum^2 by shift-add, difference, integer square root
  // two bits per cycle, then loss, mean and jitter divisions in turn.
  // Zero-reply runs bypass the arithmetic with a fixed summary.
  prs_back #(
    .COUNT_BITS (COUNT_BITS),
    .RTT_BITS   (RTT_BITS),
    .SNAP_W     (SNAP_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_sent    (out_probes_sent),
    .out_replies (out_replies_received),
    .out_loss    (out_loss_hundredths),
    .out_min     (out_min_rtt_us),
    .out_max     (out_max_rtt_us),
    .out_mean    (out_mean_rtt_us),
    .out_jitter  (out_jitter_us)
  );

endmodule
